// ----- src/pns_pkg.sv -----
// ----------------------------------------------------------------------------
// pns_pkg
// shared types and constants of the polyphonic note scheduler
// ----------------------------------------------------------------------------
package pns_pkg;

  localparam int LEVEL_W  = 9;
  localparam int NOTE_W   = 7;
  localparam int CHAN_W   = 4;
  localparam int DUR_W    = 16;
  localparam int VEL_W    = 8;
  localparam int STATUS_W = 8;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;

  localparam logic [STATUS_W-1:0] STATUS_NOTE_ON  = 8'h90;
  localparam logic [STATUS_W-1:0] STATUS_NOTE_OFF = 8'h80;
  localparam logic [VEL_W-1:0]    VEL_OFF         = 8'h00;

  // tick queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // one classified control tick
  typedef struct packed {
    logic              rise;
    logic [NOTE_W-1:0] note;
    logic [CHAN_W-1:0] chan;
    logic [VEL_W-1:0]  vel;
    logic [DUR_W-1:0]  dur;
  } tick_t;

endpackage

// ----- src/pns_ram.sv -----
// ----------------------------------------------------------------------------
// pns_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module pns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/pns_front.sv -----
// ----------------------------------------------------------------------------
// pns_front
// accepts control ticks, detects rising trigger edges, computes velocity
// ----------------------------------------------------------------------------
module pns_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [pns_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                          q_full,
  output logic                          q_push,
  output pns_pkg::tick_t                q_item
);

  logic                               prev_high_r;
  logic                               prev_high_nxt;
  logic signed [pns_pkg::LEVEL_W-1:0] level;
  logic [pns_pkg::LEVEL_W-1:0]        level_neg;
  logic                               high;

  assign level     = signed'(in_tdata[8:0]);
  assign level_neg = ~in_tdata[8:0] + 9'd1;
  assign high      = (level > 9'sd0);

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;

  always_comb begin
    q_item.rise = high && !prev_high_r;
    q_item.note = in_tdata[15:9];
    q_item.chan = in_tdata[19:16];
    // low byte of the magnitude, so -256 gives zero
    q_item.vel  = level[8] ? level_neg[7:0] : in_tdata[7:0];
    q_item.dur  = in_tdata[35:20];
  end

  assign prev_high_nxt = q_push ? high : prev_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_high_r <= 1'b0;
    end else begin
      prev_high_r <= prev_high_nxt;
    end
  end

endmodule

// ----- src/pns_queue.sv -----
// ----------------------------------------------------------------------------
// pns_queue
// short fifo of classified ticks between front and back
// ----------------------------------------------------------------------------
module pns_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pns_pkg::tick_t din,
  output logic           full,
  input  logic           pop,
  output pns_pkg::tick_t dout,
  output logic           empty
);

  pns_pkg::tick_t              mem_r [pns_pkg::QDEPTH];
  logic [pns_pkg::QPTR_W-1:0]  wptr_r, wptr_nxt;
  logic [pns_pkg::QPTR_W-1:0]  rptr_r, rptr_nxt;
  logic [pns_pkg::QCNT_W-1:0]  count_r, count_nxt;

  assign full  = (count_r == pns_pkg::QCNT_W'(pns_pkg::QDEPTH));
  assign empty = (count_r == '0);
  assign dout  = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt  = pop ? rptr_r + 1'b1 : rptr_r;
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ----- src/pns_back.sv -----
// ----------------------------------------------------------------------------
// pns_back
// voice allocation, per-tick countdown sweep and message output register
// ----------------------------------------------------------------------------
module pns_back #(
  parameter int VOICES     = 16,
  parameter int TICK_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_empty,
  output logic                           q_pop,
  input  pns_pkg::tick_t                 q_item,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [pns_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tlast
);

  localparam int IDX_W  = $clog2(VOICES);
  localparam int WORD_W = TICK_WIDTH + pns_pkg::NOTE_W + pns_pkg::CHAN_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VOICES - 1);
  localparam logic [32:0] TICK_MAX = (33'd1 << TICK_WIDTH) - 33'd1;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_SEARCH  = 4'b0010,
    ST_NOTE_ON = 4'b0100,
    ST_SCAN    = 4'b1000
  } state_t;

  state_t                          state_r, state_nxt;
  pns_pkg::tick_t                  cur_r, cur_nxt;
  logic [IDX_W-1:0]                start_r, start_nxt;
  logic [IDX_W-1:0]                ptr_r, ptr_nxt;
  logic [IDX_W-1:0]                cnt_r, cnt_nxt;
  logic [IDX_W-1:0]                idx_r, idx_nxt;
  logic [VOICES-1:0]               busy_r, busy_nxt;
  logic [VOICES-1:0]               one_r, one_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [pns_pkg::OUT_DATA_W-1:0]  out_data_r, out_data_nxt;
  logic                            out_last_r, out_last_nxt;

  logic                            ram_we, ram_re;
  logic [IDX_W-1:0]                ram_waddr, ram_raddr;
  logic [WORD_W-1:0]               ram_wdata, ram_rdata;

  logic                            out_free;
  logic [32:0]                     dur_ext;
  logic [TICK_WIDTH-1:0]           dur_sat;
  logic [TICK_WIDTH-1:0]           rd_rem, rem_dec;
  logic [pns_pkg::NOTE_W-1:0]      rd_note;
  logic [pns_pkg::CHAN_W-1:0]      rd_chan;
  logic [VOICES-1:0]               upto_idx;
  logic                            emit_off;

  pns_ram #(
    .WIDTH (WORD_W),
    .DEPTH (VOICES)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free = !out_valid_r || out_tready;

  assign dur_ext = {17'd0, cur_r.dur};
  assign dur_sat = (dur_ext > TICK_MAX) ? TICK_MAX[TICK_WIDTH-1:0]
                                        : dur_ext[TICK_WIDTH-1:0];

  assign rd_rem  = ram_rdata[WORD_W-1 -: TICK_WIDTH];
  assign rd_note = ram_rdata[pns_pkg::CHAN_W +: pns_pkg::NOTE_W];
  assign rd_chan = ram_rdata[pns_pkg::CHAN_W-1:0];
  assign rem_dec = rd_rem - TICK_WIDTH'(1);

  // slots 0..idx set; the note-off is last when no later slot ends this tick
  assign upto_idx = {VOICES{1'b1}} >> (LAST_IDX - idx_r);
  assign emit_off = busy_r[idx_r] && one_r[idx_r];

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    start_nxt     = start_r;
    ptr_nxt       = ptr_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    busy_nxt      = busy_r;
    one_nxt       = one_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_tready;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = ptr_r;
    ram_wdata     = {dur_sat, cur_r.note, cur_r.chan};
    ram_re        = 1'b0;
    ram_raddr     = '0;

    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cur_nxt = q_item;
          if (q_item.rise) begin
            ptr_nxt   = start_r;
            cnt_nxt   = '0;
            state_nxt = ST_SEARCH;
          end else begin
            ram_re    = 1'b1;
            idx_nxt   = '0;
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SEARCH: begin
        if (!busy_r[ptr_r]) begin
          ram_we         = 1'b1;
          busy_nxt[ptr_r] = (dur_sat != '0);
          one_nxt[ptr_r]  = (dur_sat == TICK_WIDTH'(1));
          start_nxt      = (start_r == LAST_IDX) ? '0 : start_r + 1'b1;
          state_nxt      = ST_NOTE_ON;
        end else if (cnt_r == LAST_IDX) begin
          // every slot busy, trigger dropped
          ram_re    = 1'b1;
          idx_nxt   = '0;
          state_nxt = ST_SCAN;
        end else begin
          ptr_nxt = (ptr_r == LAST_IDX) ? '0 : ptr_r + 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      ST_NOTE_ON: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, cur_r.vel, cur_r.note,
                           pns_pkg::STATUS_NOTE_ON | {4'h0, cur_r.chan}};
          out_last_nxt  = !(|one_r);
          ram_re        = 1'b1;
          idx_nxt       = '0;
          state_nxt     = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (!emit_off || out_free) begin
          if (busy_r[idx_r]) begin
            ram_we          = 1'b1;
            ram_waddr       = idx_r;
            ram_wdata       = {rem_dec, rd_note, rd_chan};
            busy_nxt[idx_r] = (rem_dec != '0);
            one_nxt[idx_r]  = (rem_dec == TICK_WIDTH'(1));
          end
          if (emit_off) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = {1'b0, pns_pkg::VEL_OFF, rd_note,
                             pns_pkg::STATUS_NOTE_OFF | {4'h0, rd_chan}};
            out_last_nxt  = !(|(one_r & ~upto_idx));
          end
          if (idx_r == LAST_IDX) begin
            state_nxt = ST_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = idx_r + 1'b1;
            idx_nxt   = idx_r + 1'b1;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    ptr_r      <= ptr_nxt;
    cnt_r      <= cnt_nxt;
    idx_r      <= idx_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      start_r     <= '0;
      busy_r      <= '0;
      one_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      busy_r      <= busy_nxt;
      one_r       <= one_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- src/polyphonic_note_scheduler.sv -----
// ----------------------------------------------------------------------------
// polyphonic_note_scheduler
// round-robin voice allocator for timed notes with per-tick countdown
// ----------------------------------------------------------------------------
// Each input item is one control tick. A rising trigger edge takes the first
// free voice slot found from a rotating start and sends a note-on; every tick
// then sweeps all slots, counting busy ones down and sending a note-off for
// each that reaches zero, with out_tlast on the final message of the tick.
// The back end handles one tick at a time: it fetches the tick, then sweeps
// the slots one by one through the slot memory's single read port; a rising
// edge first searches the slots, at most VOICES of them, and then sends the
// note-on. A message waiting at the output
// stalls the sweep; ticks keep being taken into a two-entry queue meanwhile.
// ----------------------------------------------------------------------------
module polyphonic_note_scheduler #(
  parameter int VOICES     = 16,
  parameter int TICK_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // trigger_level[8:0], note_number[15:9], channel[19:16],
  // duration_ticks[35:20], zero fill[39:36]
  input  logic [pns_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // status_byte[7:0], first_data[14:8], second_data[22:15], zero fill[23]
  output logic [pns_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tlast
);

  logic           q_push, q_full, q_pop, q_empty;
  pns_pkg::tick_t q_din, q_dout;

  pns_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_din)
  );

  pns_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  pns_back #(
    .VOICES     (VOICES),
    .TICK_WIDTH (TICK_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .q_item     (q_dout),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the polyphonic note scheduler
// ----------------------------------------------------------------------------
// Control ticks go in on the input stream and are scored against a local
// voice allocator model: round-robin slot search on rising trigger edges,
// per-tick countdown, note-off on expiry, tlast on the final message of a
// tick. A directed table comes first, then random ticks that mostly alternate
// low and high levels so that the voices fill and drain, with one stretch of
// long notes that occupies every slot. The sender and the receiver idle at
// varying rates, and the sender drains the block between idle patterns.
// ----------------------------------------------------------------------------
module tb_top;
  import pns_pkg::*;

  localparam int VOICES       = 16;
  localparam int RANDOM_TICKS = 290;
  localparam int LIMIT_CYCLES = 900000;
  localparam int DRAIN_CYCLES = 150;
  localparam int DIR_ROWS     = 20;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [NOTE_W-1:0]   d1;
    logic [VEL_W-1:0]    d2;
    logic                last;
  } note_msg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] lvl;
    logic [NOTE_W-1:0]  note;
    logic [CHAN_W-1:0]  chan;
    logic [DUR_W-1:0]   dur;
    logic               typed;
    logic [1:0]         n;
    note_msg_t          m0;
    note_msg_t          m1;
  } stim_row_t;

  localparam note_msg_t NO_MSG = '0;

  // rows 0..9 carry their messages, the rest are scored by the model
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    '{0,      0,   0,  0,     1, 0, NO_MSG, NO_MSG},
    '{255,    127, 15, 1,     1, 2, '{8'h9F, 127, 255, 0}, '{8'h8F, 127, 0, 1}},
    '{-256,   0,   0,  0,     1, 0, NO_MSG, NO_MSG},
    '{1,      60,  0,  0,     1, 1, '{8'h90, 60, 1, 1}, NO_MSG},
    '{-256,   5,   3,  3,     1, 0, NO_MSG, NO_MSG},
    '{255,    64,  9,  65535, 1, 1, '{8'h99, 64, 255, 1}, NO_MSG},
    '{200,    1,   1,  5,     1, 0, NO_MSG, NO_MSG},
    '{-1,     0,   0,  0,     1, 0, NO_MSG, NO_MSG},
    '{128,    72,  5,  2,     1, 1, '{8'h95, 72, 128, 1}, NO_MSG},
    '{0,      0,   0,  0,     1, 1, '{8'h85, 72, 0, 1}, NO_MSG},
    '{100,    48,  2,  3,     0, 0, NO_MSG, NO_MSG},
    '{-100,   0,   0,  0,     0, 0, NO_MSG, NO_MSG},
    '{2,      50,  7,  2,     0, 0, NO_MSG, NO_MSG},
    '{255,    10,  1,  4,     0, 0, NO_MSG, NO_MSG},
    '{-255,   127, 15, 65535, 0, 0, NO_MSG, NO_MSG},
    '{3,      90,  12, 1,     0, 0, NO_MSG, NO_MSG},
    '{0,      1,   0,  5,     0, 0, NO_MSG, NO_MSG},
    '{77,     33,  8,  6,     0, 0, NO_MSG, NO_MSG},
    '{-256,   0,   0,  0,     0, 0, NO_MSG, NO_MSG},
    '{0,      0,   0,  0,     0, 0, NO_MSG, NO_MSG}
  };

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  int src_idle_pct  = 19;
  int sink_idle_pct = 72;
  int mismatches    = 0;
  int cycles        = 0;

  // allocator model state
  logic [DUR_W-1:0]  voice_left [VOICES];
  logic [NOTE_W-1:0] voice_note [VOICES];
  logic [CHAN_W-1:0] voice_chan [VOICES];
  logic [3:0]        rr_start;
  logic              was_high;

  note_msg_t pending_msgs [$];

  polyphonic_note_scheduler #(
    .VOICES    (VOICES),
    .TICK_WIDTH(DUR_W)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0h want %0h", cycles, what, got, want);
    mismatches++;
  endtask

  // one control tick through the allocator; keep selects whether the
  // messages become expectations
  task automatic schedule_tick(input logic signed [LEVEL_W-1:0] lvl,
                               input logic [NOTE_W-1:0] note,
                               input logic [CHAN_W-1:0] chan,
                               input logic [DUR_W-1:0] dur,
                               input bit keep);
    note_msg_t batch [$];
    note_msg_t m;
    int        slot;
    int        mag;
    bit        rise;
    rise = (lvl > 0) && !was_high;
    if (rise) begin
      for (int i = 0; i < VOICES; i++) begin
        slot = (int'(rr_start) + i) % VOICES;
        if (voice_left[slot] == 0) begin
          mag = int'(lvl);
          if (mag < 0) mag = -mag;
          voice_left[slot] = dur;
          voice_note[slot] = note;
          voice_chan[slot] = chan;
          m.status = STATUS_NOTE_ON | {4'b0, chan};
          m.d1     = note;
          m.d2     = mag[7:0];
          m.last   = 1'b0;
          batch.push_back(m);
          rr_start = rr_start + 4'd1;
          break;
        end
      end
    end
    for (int i = 0; i < VOICES; i++) begin
      if (voice_left[i] != 0) begin
        voice_left[i] = voice_left[i] - 1'b1;
        if (voice_left[i] == 0) begin
          m.status = STATUS_NOTE_OFF | {4'b0, voice_chan[i]};
          m.d1     = voice_note[i];
          m.d2     = VEL_OFF;
          m.last   = 1'b0;
          batch.push_back(m);
        end
      end
    end
    was_high = (lvl > 0);
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    if (keep) begin
      foreach (batch[j]) pending_msgs.push_back(batch[j]);
    end
  endtask

  task automatic send_tick(input logic signed [LEVEL_W-1:0] lvl,
                           input logic [NOTE_W-1:0] note,
                           input logic [CHAN_W-1:0] chan,
                           input logic [DUR_W-1:0] dur,
                           input bit keep);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, dur, chan, note, lvl};
    do @(posedge clk); while (!in_tready);
    schedule_tick(lvl, note, chan, dur, keep);
  endtask

  task automatic wait_drained();
    while (pending_msgs.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin : out_check
    note_msg_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_msgs.size() == 0) begin
        report_mismatch("unexpected message", int'(out_tdata), 0);
      end else begin
        want = pending_msgs.pop_front();
        if (out_tdata[7:0] !== want.status)
          report_mismatch("status_byte", int'(out_tdata[7:0]), int'(want.status));
        if (out_tdata[14:8] !== want.d1)
          report_mismatch("first_data", int'(out_tdata[14:8]), int'(want.d1));
        if (out_tdata[22:15] !== want.d2)
          report_mismatch("second_data", int'(out_tdata[22:15]), int'(want.d2));
        if (out_tlast !== want.last)
          report_mismatch("tlast", int'(out_tlast), int'(want.last));
      end
    end
  end

  initial begin : stimulus
    stim_row_t                 row;
    logic signed [LEVEL_W-1:0] lvl;
    logic [DUR_W-1:0]          dur;
    int                        pick;
    int                        v;
    for (int i = 0; i < VOICES; i++) begin
      voice_left[i] = '0;
      voice_note[i] = '0;
      voice_chan[i] = '0;
    end
    rr_start = '0;
    was_high = 1'b0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      row = DIRECTED[r];
      send_tick(row.lvl, row.note, row.chan, row.dur, !row.typed);
      if (row.typed && row.n >= 1) pending_msgs.push_back(row.m0);
      if (row.typed && row.n >= 2) pending_msgs.push_back(row.m1);
    end

    for (int k = 0; k < RANDOM_TICKS; k++) begin
      if (k == RANDOM_TICKS / 3 || k == 2 * RANDOM_TICKS / 3) begin
        // hold the sender until the block has emptied, then swap the idle rates or, the second time, zero them
        in_tvalid <= 1'b0;
        wait_drained();
        if (k == RANDOM_TICKS / 3) begin
          src_idle_pct  = 72;
          sink_idle_pct = 19;
        end else begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      end

      pick = $urandom_range(99);
      if (pick < 85) begin
        // alternate low and high so most ticks are clean edges
        if (!was_high) begin
          lvl = LEVEL_W'($urandom_range(1, 255));
        end else begin
          v   = $urandom_range(0, 256);
          lvl = LEVEL_W'(-v);
        end
      end else begin
        lvl = LEVEL_W'($urandom_range(0, 511));
      end

      if (k >= 90 && k < 150) begin
        // long notes so that every voice ends up busy
        dur = DUR_W'($urandom_range(150, 600));
      end else begin
        pick = $urandom_range(99);
        if (pick < 10) dur = '0;
        else if (pick < 20) dur = DUR_W'(1);
        else if (pick < 80) dur = DUR_W'($urandom_range(2, 40));
        else if (pick < 99) dur = DUR_W'($urandom_range(41, 400));
        else dur = DUR_W'($urandom_range(0, 65535));
      end

      send_tick(lvl, NOTE_W'($urandom_range(0, 127)), CHAN_W'($urandom_range(0, 15)),
                dur, 1'b1);
    end
    in_tvalid <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_msgs.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
